[src/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants for the barometer compensation block
// Holds the decoded trim set, register indexes and pipeline dimensions.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // Number of register stages from input acceptance to the output register.
    localparam int NSTAGE = 10;

    // Width of the pressure accumulator, in units of 2^-32 Pa.
    localparam int ACC_W = 58;

    // Width of the temperature numerator, in units of 2^-48 degC.
    localparam int NT_W = 61;

    localparam int CFG_DATA_W = 48;

    typedef enum logic [2:0] {
        REG_TRIM_T1    = 3'd0,
        REG_TRIM_T2    = 3'd1,
        REG_TRIM_T3    = 3'd2,
        REG_TRIM_P1    = 3'd3,
        REG_TRIM_P2    = 3'd4,
        REG_TRIM_P5_P6 = 3'd5,
        REG_TRIM_P9    = 3'd6,
        REG_TRIM_SMALL = 3'd7
    } reg_idx_t;

    // Trim words already decoded: the gain trims carry their 2^14 offset removed.
    typedef struct packed {
        logic        [15:0] t1;
        logic        [15:0] t2;
        logic signed [7:0]  t3;
        logic signed [16:0] d1;
        logic signed [16:0] d2;
        logic        [15:0] p5;
        logic        [15:0] p6;
        logic signed [15:0] p9;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
    } trim_t;

    localparam logic signed [15:0] TQ8_MAX = 16'sh7FFF;
    localparam logic signed [15:0] TQ8_MIN = -16'sh8000;
    localparam logic signed [23:0] T1_MAX  = 24'sh7FFFFF;
    localparam logic signed [23:0] T1_MIN  = -24'sh800000;
    localparam logic        [23:0] PQ6_MAX = 24'hFFFFFF;

endpackage

[src/bsc_pipe_ctrl.sv]
// ----------------------------------------------------------------------------
// bsc_pipe_ctrl: valid and load-enable chain for the compensation pipeline
// A stage loads when it is empty or when the stage after it loads.
// ----------------------------------------------------------------------------
module bsc_pipe_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       out_ready,
    output logic [bsc_pkg::NSTAGE-1:0] en,
    output logic                       out_valid
);

    logic [bsc_pkg::NSTAGE-1:0] vld_reg;
    logic [bsc_pkg::NSTAGE-1:0] vld_next;

    always_comb
    begin
        en[bsc_pkg::NSTAGE-1] = !vld_reg[bsc_pkg::NSTAGE-1] || out_ready;
        for (int k = bsc_pkg::NSTAGE - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < bsc_pkg::NSTAGE; k++)
        begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[bsc_pkg::NSTAGE-1];

endmodule

[src/bsc_temp_path.sv]
// ----------------------------------------------------------------------------
// bsc_temp_path: temperature quadratic, stages one to four
// Produces the rounded, clipped Q8 temperature and the clipped Q16 value
// used by the pressure polynomial.
// ----------------------------------------------------------------------------
module bsc_temp_path
(
    input  logic                clk,
    input  logic [3:0]          en,
    input  logic [23:0]         raw_temperature,
    input  bsc_pkg::trim_t      trim,
    output logic signed [23:0]  t1,
    output logic signed [15:0]  tq8,
    output logic                sat_t
);

    logic signed [24:0]              s1_d_reg;
    logic signed [24:0]              s1_d_next;
    logic signed [41:0]              s2_a_reg;
    logic signed [41:0]              s2_a_next;
    logic signed [49:0]              s2_dd_reg;
    logic signed [49:0]              s2_dd_next;
    logic signed [bsc_pkg::NT_W-1:0] s3_nt_reg;
    logic signed [bsc_pkg::NT_W-1:0] s3_nt_next;
    logic signed [23:0]              s4_t1_reg;
    logic signed [23:0]              s4_t1_next;
    logic signed [15:0]              s4_tq8_reg;
    logic signed [15:0]              s4_tq8_next;
    logic                            s4_sat_reg;
    logic                            s4_sat_next;

    // Offset from the trimmed zero point.
    assign s1_d_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, trim.t1, 8'd0});

    assign s2_a_next  = s1_d_reg * $signed({1'b0, trim.t2});
    assign s2_dd_next = s1_d_reg * s1_d_reg;

    always_comb
    begin
        logic signed [bsc_pkg::NT_W-1:0] a_ext;
        a_ext      = bsc_pkg::NT_W'(s2_a_reg);
        s3_nt_next = (a_ext <<< 18)
                   + (bsc_pkg::NT_W'(s2_dd_reg) * bsc_pkg::NT_W'(trim.t3));
    end

    always_comb
    begin
        logic signed [bsc_pkg::NT_W-1:0] nt_rnd;
        logic signed [20:0]              tq_full;
        logic signed [28:0]              t1_full;
        nt_rnd  = s3_nt_reg + (bsc_pkg::NT_W'(1) <<< 39);
        tq_full = 21'(nt_rnd >>> 40);
        t1_full = 29'(s3_nt_reg >>> 32);
        s4_sat_next = 1'b0;
        if (tq_full > 21'(bsc_pkg::TQ8_MAX))
        begin
            s4_tq8_next = bsc_pkg::TQ8_MAX;
            s4_sat_next = 1'b1;
        end
        else if (tq_full < 21'(bsc_pkg::TQ8_MIN))
        begin
            s4_tq8_next = bsc_pkg::TQ8_MIN;
            s4_sat_next = 1'b1;
        end
        else
        begin
            s4_tq8_next = tq_full[15:0];
        end
        if (t1_full > 29'(bsc_pkg::T1_MAX))
        begin
            s4_t1_next = bsc_pkg::T1_MAX;
        end
        else if (t1_full < 29'(bsc_pkg::T1_MIN))
        begin
            s4_t1_next = bsc_pkg::T1_MIN;
        end
        else
        begin
            s4_t1_next = t1_full[23:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_d_reg <= s1_d_next;
        end
        if (en[1])
        begin
            s2_a_reg  <= s2_a_next;
            s2_dd_reg <= s2_dd_next;
        end
        if (en[2])
        begin
            s3_nt_reg <= s3_nt_next;
        end
        if (en[3])
        begin
            s4_t1_reg  <= s4_t1_next;
            s4_tq8_reg <= s4_tq8_next;
            s4_sat_reg <= s4_sat_next;
        end
    end

    assign t1    = s4_t1_reg;
    assign tq8   = s4_tq8_reg;
    assign sat_t = s4_sat_reg;

endmodule

[src/bsc_press_path.sv]
// ----------------------------------------------------------------------------
// bsc_press_path: pressure polynomial, stages one to ten
// Builds the product terms over several stages and sums them into a running
// accumulator, then rounds and clips into the output register.
// ----------------------------------------------------------------------------
module bsc_press_path
(
    input  logic                        clk,
    input  logic [bsc_pkg::NSTAGE-1:0]  en,
    input  logic [23:0]                 raw_pressure,
    input  bsc_pkg::trim_t              trim,
    input  logic signed [23:0]          t1,
    input  logic signed [15:0]          tq8,
    input  logic                        sat_t,
    output logic signed [15:0]          out_tq8,
    output logic [23:0]                 out_pq6,
    output logic                        out_sat
);

    localparam int AW = bsc_pkg::ACC_W;

    // Stage 1
    logic [23:0]          s1_p_reg;
    logic [47:0]          s1_pp_reg;
    // Stage 2
    logic [23:0]          s2_p_reg;
    logic signed [41:0]   s2_pd1_reg, s2_pd1_next;
    logic signed [41:0]   s2_pd2_reg, s2_pd2_next;
    logic signed [63:0]   s2_pp9_reg, s2_pp9_next;
    logic signed [56:0]   s2_pp10_reg, s2_pp10_next;
    logic signed [56:0]   s2_pp11_reg, s2_pp11_next;
    // Stage 3
    logic [23:0]          s3_p_reg;
    logic signed [41:0]   s3_pd2_reg;
    logic signed [40:0]   s3_j1_reg, s3_j1_next;
    logic signed [57:0]   s3_k1_reg, s3_k1_next;
    logic signed [AW-1:0] s3_acc_reg, s3_acc_next;
    // Stage 4
    logic [23:0]          s4_p_reg;
    logic signed [41:0]   s4_pd2_reg;
    logic signed [40:0]   s4_j1_reg;
    logic signed [AW-1:0] s4_acc_reg, s4_acc_next;
    // Stage 5
    logic [23:0]          s5_p_reg;
    logic signed [23:0]   s5_t1_reg;
    logic signed [47:0]   s5_t1sq_reg, s5_t1sq_next;
    logic signed [40:0]   s5_p6t1_reg, s5_p6t1_next;
    logic signed [63:0]   s5_j2_reg, s5_j2_next;
    logic signed [63:0]   s5_f2_reg, s5_f2_next;
    logic signed [AW-1:0] s5_acc_reg;
    // Stage 6
    logic [23:0]          s6_p_reg;
    logic signed [55:0]   s6_t2t1_reg, s6_t2t1_next;
    logic signed [39:0]   s6_p7t2_reg, s6_p7t2_next;
    logic signed [39:0]   s6_p3t2_reg, s6_p3t2_next;
    logic signed [63:0]   s6_j2_reg;
    logic signed [AW-1:0] s6_acc_reg, s6_acc_next;
    // Stage 7
    logic [23:0]          s7_p_reg;
    logic signed [47:0]   s7_p8t3_reg, s7_p8t3_next;
    logic signed [47:0]   s7_p4t3_reg, s7_p4t3_next;
    logic signed [63:0]   s7_g_reg, s7_g_next;
    logic signed [AW-1:0] s7_acc_reg, s7_acc_next;
    // Stage 8
    logic signed [63:0]   s8_h1_reg, s8_h1_next;
    logic signed [AW-1:0] s8_acc_reg, s8_acc_next;
    // Stage 9
    logic signed [AW-1:0] s9_acc_reg, s9_acc_next;
    // Temperature results travel alongside from stage 5 onwards.
    logic signed [15:0]   tq8_reg [5:9];
    logic                 satt_reg [5:9];
    // Stage 10
    logic signed [15:0]   o_tq8_reg;
    logic [23:0]          o_pq6_reg, o_pq6_next;
    logic                 o_sat_reg, o_sat_next;

    always_comb
    begin
        logic signed [24:0] px;
        logic signed [48:0] ppx;
        px           = $signed({1'b0, s1_p_reg});
        ppx          = $signed({1'b0, s1_pp_reg});
        s2_pd1_next  = px * trim.d1;
        s2_pd2_next  = px * trim.d2;
        s2_pp9_next  = ppx * trim.p9;
        s2_pp10_next = ppx * trim.p10;
        s2_pp11_next = ppx * trim.p11;
    end

    always_comb
    begin
        logic signed [32:0] pp11s;
        pp11s       = 33'(s2_pp11_reg >>> 24);
        s3_j1_next  = 41'(s2_pp10_reg >>> 16);
        s3_k1_next  = pp11s * $signed({1'b0, s2_p_reg});
        s3_acc_next = $signed(AW'({trim.p5, 35'd0}))
                    + (AW'(s2_pd1_reg) <<< 12)
                    + AW'(s2_pp9_reg >>> 16);
    end

    assign s4_acc_next = s3_acc_reg + AW'(s3_k1_reg >>> 9);

    assign s5_t1sq_next = t1 * t1;
    assign s5_p6t1_next = $signed({1'b0, trim.p6}) * t1;
    assign s5_j2_next   = s4_j1_reg * t1;
    assign s5_f2_next   = s4_pd2_reg * t1;

    always_comb
    begin
        logic signed [31:0] t2;
        t2           = 32'(s5_t1sq_reg >>> 16);
        s6_t2t1_next = t2 * s5_t1_reg;
        s6_p7t2_next = t2 * trim.p7;
        s6_p3t2_next = t2 * trim.p3;
        s6_acc_next  = s5_acc_reg + (AW'(s5_p6t1_reg) <<< 10) + AW'(s5_f2_reg >>> 13);
    end

    always_comb
    begin
        logic signed [39:0] t3;
        t3           = 40'(s6_t2t1_reg >>> 16);
        s7_p8t3_next = t3 * trim.p8;
        s7_p4t3_next = t3 * trim.p4;
        s7_g_next    = s6_p3t2_reg * $signed({1'b0, s6_p_reg});
        s7_acc_next  = s6_acc_reg + (AW'(s6_p7t2_reg) <<< 8) + AW'(s6_j2_reg >>> 16);
    end

    always_comb
    begin
        logic signed [39:0] p4t3s;
        p4t3s       = 40'(s7_p4t3_reg >>> 8);
        s8_h1_next  = p4t3s * $signed({1'b0, s7_p_reg});
        s8_acc_next = s7_acc_reg + (AW'(s7_p8t3_reg) <<< 1) + AW'(s7_g_reg >>> 16);
    end

    assign s9_acc_next = s8_acc_reg + AW'(s8_h1_reg >>> 13);

    // Round to 1/64 Pa and clip to the unsigned 24-bit range.
    always_comb
    begin
        logic signed [31:0] r;
        r = 32'((s9_acc_reg + (AW'(1) <<< 25)) >>> 26);
        o_sat_next = satt_reg[9];
        if (r < 32'sd0)
        begin
            o_pq6_next = '0;
            o_sat_next = 1'b1;
        end
        else if (r > $signed({8'd0, bsc_pkg::PQ6_MAX}))
        begin
            o_pq6_next = bsc_pkg::PQ6_MAX;
            o_sat_next = 1'b1;
        end
        else
        begin
            o_pq6_next = r[23:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_p_reg  <= raw_pressure;
            s1_pp_reg <= raw_pressure * raw_pressure;
        end
        if (en[1])
        begin
            s2_p_reg    <= s1_p_reg;
            s2_pd1_reg  <= s2_pd1_next;
            s2_pd2_reg  <= s2_pd2_next;
            s2_pp9_reg  <= s2_pp9_next;
            s2_pp10_reg <= s2_pp10_next;
            s2_pp11_reg <= s2_pp11_next;
        end
        if (en[2])
        begin
            s3_p_reg   <= s2_p_reg;
            s3_pd2_reg <= s2_pd2_reg;
            s3_j1_reg  <= s3_j1_next;
            s3_k1_reg  <= s3_k1_next;
            s3_acc_reg <= s3_acc_next;
        end
        if (en[3])
        begin
            s4_p_reg   <= s3_p_reg;
            s4_pd2_reg <= s3_pd2_reg;
            s4_j1_reg  <= s3_j1_reg;
            s4_acc_reg <= s4_acc_next;
        end
        if (en[4])
        begin
            s5_p_reg    <= s4_p_reg;
            s5_t1_reg   <= t1;
            s5_t1sq_reg <= s5_t1sq_next;
            s5_p6t1_reg <= s5_p6t1_next;
            s5_j2_reg   <= s5_j2_next;
            s5_f2_reg   <= s5_f2_next;
            s5_acc_reg  <= s4_acc_reg;
            tq8_reg[5]  <= tq8;
            satt_reg[5] <= sat_t;
        end
        if (en[5])
        begin
            s6_p_reg    <= s5_p_reg;
            s6_t2t1_reg <= s6_t2t1_next;
            s6_p7t2_reg <= s6_p7t2_next;
            s6_p3t2_reg <= s6_p3t2_next;
            s6_j2_reg   <= s5_j2_reg;
            s6_acc_reg  <= s6_acc_next;
            tq8_reg[6]  <= tq8_reg[5];
            satt_reg[6] <= satt_reg[5];
        end
        if (en[6])
        begin
            s7_p_reg    <= s6_p_reg;
            s7_p8t3_reg <= s7_p8t3_next;
            s7_p4t3_reg <= s7_p4t3_next;
            s7_g_reg    <= s7_g_next;
            s7_acc_reg  <= s7_acc_next;
            tq8_reg[7]  <= tq8_reg[6];
            satt_reg[7] <= satt_reg[6];
        end
        if (en[7])
        begin
            s8_h1_reg   <= s8_h1_next;
            s8_acc_reg  <= s8_acc_next;
            tq8_reg[8]  <= tq8_reg[7];
            satt_reg[8] <= satt_reg[7];
        end
        if (en[8])
        begin
            s9_acc_reg  <= s9_acc_next;
            tq8_reg[9]  <= tq8_reg[8];
            satt_reg[9] <= satt_reg[8];
        end
        if (en[9])
        begin
            o_tq8_reg <= tq8_reg[9];
            o_pq6_reg <= o_pq6_next;
            o_sat_reg <= o_sat_next;
        end
    end

    assign out_tq8 = o_tq8_reg;
    assign out_pq6 = o_pq6_reg;
    assign out_sat = o_sat_reg;

endmodule

[src/barometric_sensor_compensation.sv]
// ----------------------------------------------------------------------------
// barometric_sensor_compensation: trim polynomial compensation of a barometer
// Turns raw 24-bit pressure and temperature conversions into a compensated
// temperature in 1/256 degC and a compensated pressure in 1/64 Pa.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_*       in         tdata[23:0] raw_pressure, tdata[47:24] raw_temperature
//  m_*       out        tdata[15:0] temperature_q8, tdata[39:16] pressure_q6,
//                       tuser[0] saturated
//  cfg_*     in         trim register writes, index 0 to 7, 48-bit data
//
//  One word may enter in every cycle while the output is not held; each word
//  passes through the ten-stage multiplier pipeline, whose longest chain is
//  the temperature quadratic followed by the cubic in temperature.
//  Reset clears the valid bits and the trim registers; the datapath itself is
//  not reset. A stall on the output holds only the stages that are full, so
//  empty stages keep taking words until the pipeline has filled.
//
// ----------------------------------------------------------------------------
module barometric_sensor_compensation
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // [23:0] raw_pressure, [47:24] raw_temperature
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [15:0] temperature_q8, [39:16] pressure_q6
    output logic [0:0]  m_tuser,    // [0] saturated
    // Trim register write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [47:0] cfg_wdata
);

    bsc_pkg::trim_t                trim_reg;
    bsc_pkg::trim_t                trim_next;
    logic [bsc_pkg::NSTAGE-1:0]    en;
    logic signed [23:0]            t1;
    logic signed [15:0]            tq8;
    logic                          sat_t;
    logic signed [15:0]            out_tq8;
    logic [23:0]                   out_pq6;
    logic                          out_sat;

    // The trim words are decoded as they are written, so the pipeline sees
    // sign-extended coefficients with the pressure gain offsets removed.
    always_comb
    begin
        trim_next = trim_reg;
        if (cfg_wr_en)
        begin
            case (bsc_pkg::reg_idx_t'(cfg_addr))
                bsc_pkg::REG_TRIM_T1:    trim_next.t1 = cfg_wdata[15:0];
                bsc_pkg::REG_TRIM_T2:    trim_next.t2 = cfg_wdata[15:0];
                bsc_pkg::REG_TRIM_T3:    trim_next.t3 = $signed(cfg_wdata[7:0]);
                bsc_pkg::REG_TRIM_P1:
                    trim_next.d1 = 17'($signed(cfg_wdata[15:0])) - 17'sd16384;
                bsc_pkg::REG_TRIM_P2:
                    trim_next.d2 = 17'($signed(cfg_wdata[15:0])) - 17'sd16384;
                bsc_pkg::REG_TRIM_P5_P6:
                begin
                    trim_next.p5 = cfg_wdata[15:0];
                    trim_next.p6 = cfg_wdata[31:16];
                end
                bsc_pkg::REG_TRIM_P9:    trim_next.p9 = $signed(cfg_wdata[15:0]);
                bsc_pkg::REG_TRIM_SMALL:
                begin
                    trim_next.p3  = $signed(cfg_wdata[7:0]);
                    trim_next.p4  = $signed(cfg_wdata[15:8]);
                    trim_next.p7  = $signed(cfg_wdata[23:16]);
                    trim_next.p8  = $signed(cfg_wdata[31:24]);
                    trim_next.p10 = $signed(cfg_wdata[39:32]);
                    trim_next.p11 = $signed(cfg_wdata[47:40]);
                end
                default: trim_next = trim_reg;
            endcase
        end
    end

    // Reset values of zero decode to gain trims of minus 2^14.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_reg    <= '0;
            trim_reg.d1 <= -17'sd16384;
            trim_reg.d2 <= -17'sd16384;
        end
        else
        begin
            trim_reg <= trim_next;
        end
    end

    bsc_pipe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .en        (en),
        .out_valid (m_tvalid)
    );

    // Stages one to four: linearised temperature.
    bsc_temp_path u_temp
    (
        .clk             (clk),
        .en              (en[3:0]),
        .raw_temperature (s_tdata[47:24]),
        .trim            (trim_reg),
        .t1              (t1),
        .tq8             (tq8),
        .sat_t           (sat_t)
    );

    // Stages one to ten: pressure terms, accumulation and the output register.
    bsc_press_path u_press
    (
        .clk          (clk),
        .en           (en),
        .raw_pressure (s_tdata[23:0]),
        .trim         (trim_reg),
        .t1           (t1),
        .tq8          (tq8),
        .sat_t        (sat_t),
        .out_tq8      (out_tq8),
        .out_pq6      (out_pq6),
        .out_sat      (out_sat)
    );

    assign m_tdata = {out_pq6, out_tq8};
    assign m_tuser = out_sat;

endmodule

[src/bsc_checker.sv]
// ----------------------------------------------------------------------------
// bsc_checker: port-level checks for the barometer compensation block
// Watches the stream ports and is attached to the top level by a bind.
// ----------------------------------------------------------------------------
module bsc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A word offered but not taken stays offered unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // An empty output register never blocks the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

    // A ready sink lets the whole pipeline advance.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while the output is drained");

    // The clip flag only comes with a value at one of its limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            (m_tdata[39:16] == 24'h000000) || (m_tdata[39:16] == 24'hFFFFFF) ||
            (m_tdata[15:0] == 16'h7FFF) || (m_tdata[15:0] == 16'h8000))
        else $error("saturation flag without a clipped value");

    // Nothing is offered in the cycle after reset is released.
    assert property (@(posedge clk) $rose(rst_n) |-> !m_tvalid)
        else $error("output valid straight after reset");

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[bench/barometric_sensor_compensation_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_test: self-checking bench for the compensator
// Raw pressure and temperature words are streamed through the block under
// several trim sets. A behavioural copy of the 64-bit fixed-point polynomial
// predicts every result, and each output word is compared with it in order.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_test;

    // Limit on consecutive cycles in which no word moves on either stream.
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 400;

    typedef struct packed {
        logic [15:0] temperature_q8;
        logic [23:0] pressure_q6;
        logic        saturated;
    } reading_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [47:0] cfg_wdata;

    // Copy of the trim registers as the block should hold them.
    logic [47:0] trim_shadow [8];

    // Results predicted for accepted words, oldest first.
    reading_t    pending_readings [$];

    int          mismatches;
    bit          sender_gaps;
    bit          receiver_stalls;
    bit          long_hold_req;
    int          hold_left;
    int          quiet_cycles;

    barometric_sensor_compensation dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // Predictor: the trim polynomial in exact signed 64-bit arithmetic. An
    // arithmetic right shift of a longint floors towards minus infinity, which
    // is the rounding every term of the formula asks for.
    // ------------------------------------------------------------------------
    function automatic reading_t compensate(input logic [23:0] raw_p, input logic [23:0] raw_t);
        reading_t r;
        longint   p, rt, t1c, t2c, t3c, d1, d2, p5, p6, p9;
        longint   p3, p4, p7, p8, p10, p11;
        longint   d, nt, tq8, tp1, tp2, tp3, pp, acc, pq6;
        logic [47:0] sb;
        bit       sat;
        p   = raw_p;
        rt  = raw_t;
        t1c = trim_shadow[bsc_pkg::REG_TRIM_T1][15:0];
        t2c = trim_shadow[bsc_pkg::REG_TRIM_T2][15:0];
        t3c = longint'($signed(trim_shadow[bsc_pkg::REG_TRIM_T3][7:0]));
        d1  = longint'($signed(trim_shadow[bsc_pkg::REG_TRIM_P1][15:0])) - 16384;
        d2  = longint'($signed(trim_shadow[bsc_pkg::REG_TRIM_P2][15:0])) - 16384;
        p5  = trim_shadow[bsc_pkg::REG_TRIM_P5_P6][15:0];
        p6  = trim_shadow[bsc_pkg::REG_TRIM_P5_P6][31:16];
        p9  = longint'($signed(trim_shadow[bsc_pkg::REG_TRIM_P9][15:0]));
        sb  = trim_shadow[bsc_pkg::REG_TRIM_SMALL];
        p3  = longint'($signed(sb[7:0]));
        p4  = longint'($signed(sb[15:8]));
        p7  = longint'($signed(sb[23:16]));
        p8  = longint'($signed(sb[31:24]));
        p10 = longint'($signed(sb[39:32]));
        p11 = longint'($signed(sb[47:40]));
        sat = 1'b0;

        // Temperature numerator in units of 2^-48 degC.
        d  = rt - t1c * 256;
        nt = d * t2c * 262144 + d * d * t3c;

        tq8 = (nt + (longint'(1) <<< 39)) >>> 40;
        if (tq8 > 32767)
        begin
            tq8 = 32767;
            sat = 1'b1;
        end
        if (tq8 < -32768)
        begin
            tq8 = -32768;
            sat = 1'b1;
        end

        // The pressure path uses a Q16 temperature clipped to +-128 degC.
        tp1 = nt >>> 32;
        if (tp1 > 8388607)
            tp1 = 8388607;
        if (tp1 < -8388608)
            tp1 = -8388608;
        tp2 = (tp1 * tp1) >>> 16;
        tp3 = (tp2 * tp1) >>> 16;

        pp  = p * p;
        acc = p5 * (longint'(1) <<< 35);
        acc += p6 * tp1 * 1024;
        acc += p7 * tp2 * 256;
        acc += p8 * tp3 * 2;
        acc += p * d1 * 4096;
        acc += (p * d2 * tp1) >>> 13;
        acc += (p * p3 * tp2) >>> 16;
        acc += (((p4 * tp3) >>> 8) * p) >>> 13;
        acc += (pp * p9) >>> 16;
        acc += (((pp * p10) >>> 16) * tp1) >>> 16;
        acc += (((pp * p11) >>> 24) * p) >>> 9;

        pq6 = (acc + (longint'(1) <<< 25)) >>> 26;
        if (pq6 < 0)
        begin
            pq6 = 0;
            sat = 1'b1;
        end
        if (pq6 > 16777215)
        begin
            pq6 = 16777215;
            sat = 1'b1;
        end

        r.temperature_q8 = tq8[15:0];
        r.pressure_q6    = pq6[23:0];
        r.saturated      = sat;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Output side: random stall bursts, plus one long hold on request so that
    // the pipeline fills and back-pressures the input.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end
        else if (long_hold_req)
        begin
            m_tready  <= 1'b0;
            hold_left <= LONG_HOLD;
        end
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (receiver_stalls && $urandom_range(0, 7) == 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= $urandom_range(0, 10);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Every accepted output word is compared with the oldest prediction.
    always @(posedge clk)
    begin
        reading_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.temperature_q8 = m_tdata[15:0];
            got.pressure_q6    = m_tdata[39:16];
            got.saturated      = m_tuser[0];
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word: temp %h pres %h sat %b",
                             got.temperature_q8, got.pressure_q6, got.saturated);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected temp %h pres %h sat %b, got temp %h pres %h sat %b",
                                 want.temperature_q8, want.pressure_q6, want.saturated,
                                 got.temperature_q8, got.pressure_q6, got.saturated);
                end
            end
        end
    end

    // Watchdog on cycles in which neither stream moves a word.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Shared helpers.
    // ------------------------------------------------------------------------

    // Offers one word and waits for the block to take it. Valid is left high
    // so that back-to-back words stream without a bubble.
    task automatic send_reading(input logic [23:0] raw_p, input logic [23:0] raw_t);
        if (sender_gaps && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {raw_t, raw_p};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_readings.push_back(compensate(raw_p, raw_t));
    endtask

    // Lowers valid and waits until every predicted word has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (bsc_pkg::NSTAGE + 2) @(posedge clk);
    endtask

    // Writes all eight trim registers; only called while the block is idle.
    task automatic load_trims(input logic [47:0] t1, t2, t3, p1, p2, p56, p9, sbytes);
        logic [47:0] vals [8];
        vals = '{t1, t2, t3, p1, p2, p56, p9, sbytes};
        for (int i = 0; i < 8; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= bsc_pkg::reg_idx_t'(i);
            cfg_wdata <= vals[i];
            @(posedge clk);
            case (i)
                bsc_pkg::REG_TRIM_P5_P6: trim_shadow[i] = vals[i] & 48'hFFFF_FFFF;
                bsc_pkg::REG_TRIM_SMALL: trim_shadow[i] = vals[i];
                bsc_pkg::REG_TRIM_T3:    trim_shadow[i] = vals[i] & 48'hFF;
                default:                 trim_shadow[i] = vals[i] & 48'hFFFF;
            endcase
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_typical_trims();
        // Values of the order a real part carries in its trim memory.
        load_trims(48'd27500, 48'd19000, 48'hF9, 48'hF830, 48'hF448,
                   48'({16'd24000, 16'd20000}), 48'd15000,
                   {8'hCE, 8'd15, 8'hFB, 8'd3, 8'd5, 8'd10});
    endtask

    function automatic logic [23:0] plausible_raw();
        // Centred on the conversion range a working sensor produces.
        return 24'd6_000_000 + 24'($urandom_range(0, 2_500_000));
    endfunction

    function automatic logic [47:0] random_trim();
        return 48'({$urandom, $urandom});
    endfunction

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Trims still at their reset value of zero.
    task automatic test_reset_trims();
        send_reading(24'h000000, 24'h000000);
        send_reading(24'hFFFFFF, 24'hFFFFFF);
        send_reading(24'h800000, 24'h7FFFFF);
        wait_drained();
    endtask

    // Field extremes and both clipping cases of each output.
    task automatic test_extremes();
        load_typical_trims();
        send_reading(24'h000000, 24'h000000);
        send_reading(24'hFFFFFF, 24'h000000);
        send_reading(24'h000000, 24'hFFFFFF);
        send_reading(24'hFFFFFF, 24'hFFFFFF);
        send_reading(24'h555555, 24'hAAAAAA);
        send_reading(24'hAAAAAA, 24'h555555);
        send_reading(24'd8_000_000, 24'd7_040_000);
        wait_drained();
        // Strong linear trim with offset zero drives temperature high, and
        // a large offset drives it low; the pressure path clips with it.
        load_trims(48'd0, 48'hFFFF, 48'h7F, 48'h7FFF, 48'h8000,
                   48'({16'hFFFF, 16'h0000}), 48'h7FFF, 48'h7F80_7F80_7F80);
        send_reading(24'hFFFFFF, 24'hFFFFFF);
        send_reading(24'h000001, 24'h800000);
        send_reading(24'h7FFFFF, 24'h000000);
        wait_drained();
        load_trims(48'hFFFF, 48'hFFFF, 48'h80, 48'h8000, 48'h7FFF,
                   48'({16'h0000, 16'hFFFF}), 48'h8000, 48'h807F_807F_807F);
        send_reading(24'h000000, 24'h000000);
        send_reading(24'hFFFFFF, 24'h000000);
        send_reading(24'hFFFFFF, 24'hFFFFFF);
        send_reading(24'h123456, 24'hFFFF00);
        wait_drained();
    endtask

    // Several trim sets: all ones, all zeros, random; random words under each.
    task automatic test_trim_sweep();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        for (int set = 0; set < 5; set++)
        begin
            if (set == 0)
                load_trims('1, '1, '1, '1, '1, '1, '1, '1);
            else if (set == 1)
                load_trims('0, '0, '0, '0, '0, '0, '0, '0);
            else
                load_trims(random_trim(), random_trim(), random_trim(), random_trim(),
                           random_trim(), random_trim(), random_trim(), random_trim());
            for (int i = 0; i < 60; i++)
                send_reading(24'($urandom), 24'($urandom));
            wait_drained();
        end
    endtask

    // Bulk traffic with a realistic trim set, mostly plausible readings.
    task automatic test_typical_traffic();
        load_typical_trims();
        for (int i = 0; i < 1000; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_reading(24'($urandom), 24'($urandom));
            else
                send_reading(plausible_raw(), plausible_raw());
        end
        wait_drained();
    endtask

    // Output held for a long stretch while words keep arriving.
    task automatic test_backpressure();
        sender_gaps   = 1'b0;
        long_hold_req = 1'b1;
        // The request stands until the receiver has taken it up.
        wait (hold_left > LONG_HOLD - 4);
        long_hold_req = 1'b0;
        for (int i = 0; i < 60; i++)
            send_reading(plausible_raw(), 24'($urandom));
        wait_drained();
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_full_rate();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        for (int i = 0; i < 300; i++)
            send_reading(24'($urandom), plausible_raw());
        wait_drained();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        cfg_wr_en       = 1'b0;
        cfg_addr        = '0;
        cfg_wdata       = '0;
        mismatches      = 0;
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        long_hold_req   = 1'b0;
        quiet_cycles    = 0;
        for (int i = 0; i < 8; i++)
            trim_shadow[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_trims();
        test_extremes();
        test_trim_sweep();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        test_typical_traffic();
        test_backpressure();
        test_full_rate();

        // Anything still predicted at this point never came out.
        mismatches += pending_readings.size();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[barometric_sensor_compensation.f]
src/bsc_pkg.sv
src/bsc_pipe_ctrl.sv
src/bsc_temp_path.sv
src/bsc_press_path.sv
src/barometric_sensor_compensation.sv
src/bsc_checker.sv
bench/barometric_sensor_compensation_test.sv
